// File: hw/rtl/time_window_snapshot_buffer_unit_macros.svh
// Assertion macros used by the snapshot buffer checker.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef TIME_WINDOW_SNAPSHOT_BUFFER_UNIT_MACROS_SVH
`define TIME_WINDOW_SNAPSHOT_BUFFER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the clock and off during reset.
`define TWSB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the clock and off during reset.
`define TWSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/twsb_pkg.sv
// Shared types, codes and constants of the snapshot trace buffer.
// No dependencies; every RTL module in the other files imports this package.
`timescale 1ns / 1ps

package twsb_pkg;

    // Default store depth and the cap on results of one dump.
    localparam int TWSB_DEPTH  = 64;
    localparam int MAX_RESULTS = 64;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    // Running byte total saturates at its full width.
    localparam int TOTAL_W = 38;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Request codes.
    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_DUMP   = 2'd2;
    localparam logic [1:0] REQ_STATUS = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 43;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT  = 2'd2;

    // Input beat.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [62:0] stamp;
        logic [30:0] payload_bytes;
        logic [31:0] stored_bytes;
        logic [31:0] entry_tag;
        logic [62:0] range_start;
        logic [62:0] range_stop;
    } req_t;

    // Result beat.
    typedef struct packed {
        logic         accepted;
        logic         time_reversal_clear;
        logic         item_valid;
        logic [31:0]  item_tag;
        logic [62:0]  item_time;
        logic [6:0]   fill_count;
        logic [37:0]  bytes_used;
        logic [62:0]  oldest_time;
        logic [62:0]  latest_time;
        logic         last;
    } rsp_t;

    // One stored entry.
    typedef struct packed {
        logic [31:0] entry_tag;
        logic [62:0] entry_time;
        logic [31:0] entry_size;
    } entry_t;

    // Decisions of the limit evaluator for the sequencer.
    typedef struct packed {
        logic rev;
        logic drop;
        logic pop;
    } limit_flags_t;

endpackage

// File: hw/rtl/twsb_entry_ram.sv
// Entry store: one write port, one read port with registered read data.
// Depends on twsb_pkg for the entry type.
`timescale 1ns / 1ps

module twsb_entry_ram
    import twsb_pkg::*;
#(
    parameter int DEPTH = TWSB_DEPTH
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  entry_t                   wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output entry_t                   rd_data
);

    entry_t mem_array [DEPTH];
    entry_t rd_data_reg;

    // Write, and registered read (old data on a collision).
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_array[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/twsb_limit_eval.sv
// Limit evaluation for a push: time reversal, oversize drop and eviction test.
// Depends on twsb_pkg for the request, entry and flag types.
`timescale 1ns / 1ps

module twsb_limit_eval
    import twsb_pkg::*;
#(
    parameter int DEPTH = TWSB_DEPTH
) (
    input  req_t                       req,
    input  logic [$clog2(DEPTH+1)-1:0] count,
    input  logic [TOTAL_W-1:0]         total,
    input  logic [62:0]                newest,
    input  entry_t                     head_entry,
    input  logic [31:0]                byte_limit,
    input  logic [42:0]                window_limit,
    input  logic [7:0]                 entry_limit,
    output limit_flags_t               flags
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > 8) ? CW : 8;

    logic              byte_on;
    logic              win_on;
    logic              cnt_on;
    logic [TOTAL_W:0]  byte_sum;
    logic [63:0]       age;
    logic              byte_hit;
    logic              win_hit;
    logic              cnt_hit;
    logic              full_hit;

    // A negative limit switches that check off.
    assign byte_on = !byte_limit[31];
    assign win_on  = !window_limit[42];
    assign cnt_on  = !entry_limit[7];

    // Checks made once per push before any eviction.
    assign flags.rev  = (count != '0) && (req.stamp < newest);
    assign flags.drop = byte_on && ({1'b0, req.payload_bytes} > byte_limit);

    // Eviction test against the entry currently at the head.
    assign byte_sum = {1'b0, total} + (TOTAL_W + 1)'(req.payload_bytes);
    assign byte_hit = byte_on && (byte_sum > (TOTAL_W + 1)'(byte_limit));

    assign age     = {1'b0, req.stamp} - {1'b0, head_entry.entry_time};
    assign win_hit = win_on && ($signed(age) > $signed({21'b0, window_limit}));

    assign cnt_hit  = cnt_on && (CMP_W'(count) >= CMP_W'(entry_limit[6:0]));
    assign full_hit = (count >= CW'(DEPTH));

    assign flags.pop = (count != '0) && (byte_hit || win_hit || cnt_hit || full_hit);

endmodule

// File: hw/rtl/time_window_snapshot_buffer_unit.sv
// Snapshot trace buffer top level; uses twsb_pkg, twsb_entry_ram and twsb_limit_eval.
// Flow: a push goes through prep, evict (E evictions, one per cycle) and resp to the
// registered result, a dropped push skips evict; clear, status and an empty dump go to resp.
// A dump scans one entry per cycle while the output register can take its beats, and its
// last beat ends the scan at the range end, the last stored entry or the result cap.
// Throughput: one request at a time, the next beat is taken once the sequencer is back in
// idle. Reset clears control state and sets all limits to -1; the entry store is not cleared.
`timescale 1ns / 1ps

module time_window_snapshot_buffer_unit
    import twsb_pkg::*;
#(
    parameter int DEPTH = TWSB_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  req_t                  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rsp_t                  m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = AW + 1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PREP  = 6'b000010,
        ST_EVICT = 6'b000100,
        ST_DUMP  = 6'b001000,
        ST_TAIL  = 6'b010000,
        ST_RESP  = 6'b100000
    } state_t;

    // Circular slot of an offset from the head.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [OW-1:0] off);
        logic [OW-1:0] sum;
        sum = OW'(base) + off;
        if (sum >= OW'(DEPTH)) begin
            sum = sum - OW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [62:0]         newest_reg, newest_next;
    logic [62:0]         oldest_reg, oldest_next;
    logic                acc_flag_reg, acc_flag_next;
    logic                rev_flag_reg, rev_flag_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [31:0]         pend_tag_reg, pend_tag_next;
    logic [62:0]         pend_time_reg, pend_time_next;
    logic [NRES_W-1:0]   nres_reg, nres_next;
    logic                out_valid_reg, out_valid_next;
    rsp_t                out_data_reg, out_data_next;
    logic [31:0]         byte_limit_reg;
    logic [42:0]         window_limit_reg;
    logic [7:0]          entry_limit_reg;

    logic                out_free;
    logic                out_load;
    rsp_t                rsp_base;
    rsp_t                out_new;
    logic [TOTAL_W:0]    total_sum;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    entry_t              wr_data;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       dump_addr;
    entry_t              rd_data;
    limit_flags_t        flags;
    logic                dump_adv;
    logic                in_lo;
    logic                beyond;
    logic                is_end;
    logic                max_hit;

    // Entry store.
    twsb_entry_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Reversal, drop and eviction decisions.
    twsb_limit_eval #(
        .DEPTH (DEPTH)
    ) u_limit (
        .req          (req_reg),
        .count        (count_reg),
        .total        (total_reg),
        .newest       (newest_reg),
        .head_entry   (rd_data),
        .byte_limit   (byte_limit_reg),
        .window_limit (window_limit_reg),
        .entry_limit  (entry_limit_reg),
        .flags        (flags)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    // Saturating byte total after an append.
    assign total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(req_reg.stored_bytes);

    // Dump range tests on the entry read this cycle.
    assign in_lo   = (req_reg.range_start == '0) || (rd_data.entry_time >= req_reg.range_start);
    assign beyond  = (req_reg.range_stop != '0) && (rd_data.entry_time > req_reg.range_stop);
    assign is_end  = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign max_hit = (nres_reg == NRES_W'(MAX_RESULTS - 1));

    // Status part common to every result beat.
    always_comb begin
        rsp_base             = '0;
        rsp_base.fill_count  = 7'(count_reg);
        rsp_base.bytes_used  = total_reg;
        rsp_base.oldest_time = (count_reg != '0) ? oldest_reg : '0;
        rsp_base.latest_time = (count_reg != '0) ? newest_reg : '0;
        rsp_base.last        = 1'b1;
    end

    // Append write: new entry goes behind the newest one.
    always_comb begin
        wr_addr            = slot_of(head_reg, OW'(count_reg));
        wr_data.entry_tag  = req_reg.entry_tag;
        wr_data.entry_time = req_reg.stamp;
        wr_data.entry_size = req_reg.stored_bytes;
    end

    // Request sequencer.
    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        newest_next     = newest_reg;
        oldest_next     = oldest_reg;
        acc_flag_next   = acc_flag_reg;
        rev_flag_next   = rev_flag_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_tag_next   = pend_tag_reg;
        pend_time_next  = pend_time_reg;
        nres_next       = nres_reg;
        out_load        = 1'b0;
        out_new         = rsp_base;
        wr_en           = 1'b0;
        dump_adv        = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next      = s_data;
                    acc_flag_next = 1'b0;
                    rev_flag_next = 1'b0;
                    case (s_data.req_type)
                        REQ_PUSH: begin
                            state_next = ST_PREP;
                        end
                        REQ_CLEAR: begin
                            head_next  = '0;
                            count_next = '0;
                            total_next = '0;
                            state_next = ST_RESP;
                        end
                        REQ_DUMP: begin
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                            nres_next       = '0;
                            state_next      = (count_reg == '0) ? ST_RESP : ST_DUMP;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            // Time reversal empties the buffer; an oversized payload is dropped.
            ST_PREP: begin
                rev_flag_next = flags.rev;
                if (flags.rev) begin
                    head_next  = '0;
                    count_next = '0;
                    total_next = '0;
                end
                state_next = flags.drop ? ST_RESP : ST_EVICT;
            end

            // One eviction per cycle, then the append.
            ST_EVICT: begin
                if (flags.pop) begin
                    total_next = (total_reg >= TOTAL_W'(rd_data.entry_size)) ?
                                 total_reg - TOTAL_W'(rd_data.entry_size) : '0;
                    count_next = count_reg - CW'(1);
                    head_next  = (count_reg == CW'(1)) ? '0 : slot_of(head_reg, OW'(1));
                end else begin
                    wr_en         = 1'b1;
                    count_next    = count_reg + CW'(1);
                    total_next    = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
                    newest_next   = req_reg.stamp;
                    oldest_next   = (count_reg == '0) ? req_reg.stamp : rd_data.entry_time;
                    acc_flag_next = 1'b1;
                    state_next    = ST_RESP;
                end
            end

            // Scan oldest to newest; an in-range entry is held back one step so
            // that the final one can be marked.
            ST_DUMP: begin
                if (in_lo && !beyond) begin
                    if (pend_valid_reg) begin
                        if (out_free) begin
                            out_load           = 1'b1;
                            out_new.item_valid = 1'b1;
                            out_new.item_tag   = pend_tag_reg;
                            out_new.item_time  = pend_time_reg;
                            out_new.last       = max_hit;
                            nres_next          = nres_reg + NRES_W'(1);
                            pend_tag_next      = rd_data.entry_tag;
                            pend_time_next     = rd_data.entry_time;
                            if (max_hit) begin
                                state_next = ST_IDLE;
                            end else if (is_end) begin
                                state_next = ST_TAIL;
                            end
                        end else begin
                            dump_adv = 1'b0;
                        end
                    end else begin
                        pend_valid_next = 1'b1;
                        pend_tag_next   = rd_data.entry_tag;
                        pend_time_next  = rd_data.entry_time;
                        if (is_end) begin
                            state_next = ST_TAIL;
                        end
                    end
                end else if (beyond || is_end) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        if (pend_valid_reg) begin
                            out_new.item_valid = 1'b1;
                            out_new.item_tag   = pend_tag_reg;
                            out_new.item_time  = pend_time_reg;
                        end
                        state_next = ST_IDLE;
                    end else begin
                        dump_adv = 1'b0;
                    end
                end
                if (dump_adv) begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            // Final held entry of a dump.
            ST_TAIL: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    out_new.item_valid = 1'b1;
                    out_new.item_tag   = pend_tag_reg;
                    out_new.item_time  = pend_time_reg;
                    state_next         = ST_IDLE;
                end
            end

            // Single result beat for push, clear, status and an empty dump.
            ST_RESP: begin
                if (out_free) begin
                    out_load                    = 1'b1;
                    out_new.accepted            = acc_flag_reg;
                    out_new.time_reversal_clear = rev_flag_reg;
                    state_next                  = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Read address: the dump scan position, otherwise always the head, so the
    // head entry is on the read port in every cycle of a push.
    assign dump_addr = slot_of(head_reg, OW'(idx_reg) + (dump_adv ? OW'(1) : OW'(0)));
    assign rd_addr   = (state_reg == ST_DUMP) ? dump_addr : head_next;

    // Output register.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = out_new;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request, scan and result payload.
    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        newest_reg     <= newest_next;
        oldest_reg     <= oldest_next;
        acc_flag_reg   <= acc_flag_next;
        rev_flag_reg   <= rev_flag_next;
        idx_reg        <= idx_next;
        pend_valid_reg <= pend_valid_next;
        pend_tag_reg   <= pend_tag_next;
        pend_time_reg  <= pend_time_next;
        nres_reg       <= nres_next;
        out_data_reg   <= out_data_next;
    end

    // Limit registers; a negative value means the limit is off.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_limit_reg   <= '1;
            window_limit_reg <= '1;
            entry_limit_reg  <= '1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BYTE_LIMIT: begin
                    byte_limit_reg <= cfg_data[31:0];
                end
                CFG_WINDOW_LIMIT: begin
                    window_limit_reg <= cfg_data[42:0];
                end
                CFG_ENTRY_LIMIT: begin
                    entry_limit_reg <= cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/twsb_checker.sv
// Port-level checker for the snapshot buffer, bound to the top level.
// Depends on twsb_pkg and time_window_snapshot_buffer_unit_macros.svh.
`timescale 1ns / 1ps
`include "time_window_snapshot_buffer_unit_macros.svh"

module twsb_checker
    import twsb_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input rsp_t m_data
);

    // A stalled result beat holds.
    `TWSB_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")

    // Entries are kept oldest first, so the window never runs backwards.
    `TWSB_ASSERT_IMPL(a_window_order, m_valid, m_data.oldest_time <= m_data.latest_time, "oldest time after newest time")

    // A dumped entry lies inside the reported window and carries no push flags.
    `TWSB_ASSERT_IMPL(a_item_in_window, m_valid && m_data.item_valid, !m_data.accepted && !m_data.time_reversal_clear && m_data.item_time >= m_data.oldest_time && m_data.item_time <= m_data.latest_time, "dumped entry outside window")

    // A stored push answers with exactly one beat.
    `TWSB_ASSERT_IMPL(a_push_single, m_valid && m_data.accepted, m_data.last && !m_data.item_valid, "push result not a single beat")

    // Requests are worked one at a time.
    `TWSB_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "input taken while a request is in progress")

endmodule

bind time_window_snapshot_buffer_unit twsb_checker u_twsb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
